// File: design/ffa_pkg.sv
// Shared types, codes and helpers for the first-fit frame allocator.
package ffa_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int WIDX_W    = 11;
  localparam int FIDX_W    = 16;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] frame_in;
  } ffa_in_t;

  typedef struct packed {
    logic [7:0] frame_out;
    logic       is_used;
    logic [1:0] status;
    logic [8:0] used_count;
  } ffa_out_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        op;
    logic              tgt_en;
    logic [WIDX_W-1:0] tgt_word;
    logic [BIT_W-1:0]  tgt_bit;
    logic              found;
    logic [FIDX_W-1:0] grant;
    logic              cleared;
    logic              used_bit;
  } ffa_tok_t;

  function automatic logic [WORD_BITS-1:0] word_mask(int widx, int lo, int hi);
    logic [WORD_BITS-1:0] m;
    int                   g;
    m = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      g = widx * WORD_BITS + j;
      m[j] = (g >= lo) && (g < hi);
    end
    return m;
  endfunction

endpackage

// File: design/ffa_cell.sv
// One map cell: holds 32 frame bits and serves the passing command token.
module ffa_cell #(
  parameter int CELL_IDX        = 0,
  parameter int NUM_FRAMES      = 256,
  parameter int RESERVED_FRAMES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ffa_pkg::ffa_tok_t tok_in,
  output ffa_pkg::ffa_tok_t tok_out
);
  import ffa_pkg::*;

  localparam logic [WORD_BITS-1:0] RST_WORD = word_mask(CELL_IDX, 0, RESERVED_FRAMES);
  localparam logic [WORD_BITS-1:0] USR_MASK =
    word_mask(CELL_IDX, RESERVED_FRAMES, NUM_FRAMES);
  localparam logic [WIDX_W-1:0] MY_WORD = WIDX_W'(CELL_IDX);
  localparam logic [FIDX_W-1:0] BASE    = FIDX_W'(CELL_IDX * WORD_BITS);

  logic [WORD_BITS-1:0] word_r, word_nxt;
  ffa_tok_t             tok_r, tok_nxt;
  logic [WORD_BITS-1:0] free_vec, low_hot;
  logic [BIT_W-1:0]     pos;
  logic                 hit;

  always_comb begin
    free_vec = ~word_r & USR_MASK;
    low_hot  = free_vec & (~free_vec + WORD_BITS'(1));
    pos      = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low_hot[j]) pos = pos | BIT_W'(j);
    end
  end

  assign hit = tok_in.tgt_en && (tok_in.tgt_word == MY_WORD);

  always_comb begin
    word_nxt = word_r;
    tok_nxt  = tok_in;
    if (tok_in.valid) begin
      unique case (tok_in.op)
        OP_ALLOC: begin
          if (!tok_in.found && (free_vec != '0)) begin
            word_nxt      = word_r | low_hot;
            tok_nxt.found = 1'b1;
            tok_nxt.grant = BASE | FIDX_W'(pos);
          end
        end
        OP_FREE: begin
          if (hit && word_r[tok_in.tgt_bit]) begin
            word_nxt[tok_in.tgt_bit] = 1'b0;
            tok_nxt.cleared          = 1'b1;
          end
        end
        OP_QUERY: begin
          if (hit) tok_nxt.used_bit = word_r[tok_in.tgt_bit];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= RST_WORD;
      tok_r  <= '0;
    end else begin
      word_r <= word_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: design/first_fit_frame_allocator_unit.sv
// Top level of the first-fit frame allocator: command launch, cell chain, result.
//
// Usage:
//   Command channel: drive in_item with start high; the command transfers at
//   a rising edge where start is high and busy is low. busy stays high until
//   out_valid rises.
//   Result channel: out_item is valid for exactly one cycle with out_valid
//   high; the receiver must take it then, it cannot stall the block.
//   The map lives in a chain of 32-bit cells, ceil(NUM_FRAMES/32) of them.
//   A command token walks one cell per cycle; allocate takes the lowest free
//   user frame in the first cell that has one, free and query act in the
//   cell that owns the frame.
//   Timing: the command token passes through every cell register in order,
//   and out_valid is registered from the token leaving the last cell. busy drops with
//   out_valid, so the next command can transfer at the edge that takes the
//   result; no new command is taken while the last one is still in the chain.
//   Reset (rst_n low, synchronous): kernel frames are marked used, all other
//   frames free, the used count is the kernel frame count, busy is low.
module first_fit_frame_allocator_unit #(
  parameter int NUM_FRAMES      = 256,
  parameter int RESERVED_FRAMES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ffa_pkg::ffa_in_t  in_item,
  output logic              out_valid,
  output ffa_pkg::ffa_out_t out_item
);
  import ffa_pkg::*;

  localparam int NW      = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int CW      = $clog2(NUM_FRAMES + 1);
  localparam int KFRAMES = (RESERVED_FRAMES < NUM_FRAMES) ? RESERVED_FRAMES : NUM_FRAMES;

  ffa_tok_t         chain [NW+1];
  ffa_tok_t         launch, done_tok;
  logic             accept;
  logic [31:0]      frame32;
  logic             free_ok, query_ok;
  logic             busy_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [31:0]      cnt_ext;
  logic             out_valid_r;
  ffa_out_t         out_r, out_nxt;

  assign accept  = start && !busy_r;
  assign frame32 = 32'(in_item.frame_in);
  assign free_ok = (frame32 < 32'(NUM_FRAMES)) && (frame32 >= 32'(RESERVED_FRAMES));
  assign query_ok = frame32 < 32'(NUM_FRAMES);

  always_comb begin
    launch          = '0;
    launch.valid    = accept;
    launch.op       = in_item.op;
    launch.tgt_word = WIDX_W'(in_item.frame_in[7:BIT_W]);
    launch.tgt_bit  = in_item.frame_in[BIT_W-1:0];
    launch.tgt_en   = ((in_item.op == OP_FREE) && free_ok) ||
                      ((in_item.op == OP_QUERY) && query_ok);
  end

  assign chain[0] = launch;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    ffa_cell #(
      .CELL_IDX        (i),
      .NUM_FRAMES      (NUM_FRAMES),
      .RESERVED_FRAMES (RESERVED_FRAMES)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign done_tok = chain[NW];

  always_comb begin
    cnt_nxt = cnt_r;
    if (done_tok.op == OP_ALLOC && done_tok.found) cnt_nxt = cnt_r + CW'(1);
    if (done_tok.op == OP_FREE && done_tok.cleared) cnt_nxt = cnt_r - CW'(1);
  end

  assign cnt_ext = 32'(cnt_nxt);

  always_comb begin
    out_nxt            = '0;
    out_nxt.used_count = cnt_ext[8:0];
    out_nxt.is_used    = (done_tok.op == OP_QUERY) && done_tok.used_bit;
    unique case (done_tok.op)
      OP_ALLOC: begin
        out_nxt.frame_out = done_tok.found ? done_tok.grant[7:0] : 8'd0;
        out_nxt.status    = done_tok.found ? ST_OK : ST_FULL;
      end
      OP_FREE:  out_nxt.status = done_tok.tgt_en ? ST_OK : ST_INVALID;
      OP_QUERY: out_nxt.status = ST_OK;
      default:  out_nxt.status = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= CW'(KFRAMES);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done_tok.valid;
      if (accept) busy_r <= 1'b1;
      else if (done_tok.valid) busy_r <= 1'b0;
      if (done_tok.valid) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done_tok.valid) out_r <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: tb/sv/tb_first_fit_frame_allocator_unit.sv
// Testbench for the first-fit frame allocator: directed and random command transfers against a scoreboard.
`timescale 1ns / 1ps

module tb_first_fit_frame_allocator_unit;
  import ffa_pkg::*;

  localparam int NUM_FRAMES      = 256;
  localparam int RESERVED_FRAMES = 16;
  localparam int RSVD_COUNT      =
    (RESERVED_FRAMES < NUM_FRAMES) ? RESERVED_FRAMES : NUM_FRAMES;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 20;

  localparam logic [1:0] OP_BAD = 2'd3;

  class alloc_scoreboard;
    bit          frame_taken[NUM_FRAMES];
    int unsigned taken_count;
    ffa_out_t    expected_q[$];
    int unsigned errors;

    function new();
      for (int f = 0; f < NUM_FRAMES; f++) frame_taken[f] = (f < RSVD_COUNT);
      taken_count = RSVD_COUNT;
      errors = 0;
    endfunction

    function void note_cmd(ffa_in_t cmd);
      ffa_out_t want;
      bit       granted;
      want = '0;
      want.status = ST_OK;
      granted = 1'b0;
      case (cmd.op)
        OP_ALLOC: begin
          want.status = ST_FULL;
          for (int f = RSVD_COUNT; f < NUM_FRAMES; f++) begin
            if (!granted && !frame_taken[f]) begin
              granted        = 1'b1;
              frame_taken[f] = 1'b1;
              taken_count++;
              want.frame_out = f[7:0];
              want.status    = ST_OK;
            end
          end
        end
        OP_FREE: begin
          if (cmd.frame_in >= NUM_FRAMES || cmd.frame_in < RESERVED_FRAMES) begin
            want.status = ST_INVALID;
          end else if (frame_taken[cmd.frame_in]) begin
            frame_taken[cmd.frame_in] = 1'b0;
            taken_count--;
          end
        end
        OP_QUERY: begin
          if (cmd.frame_in < NUM_FRAMES) want.is_used = frame_taken[cmd.frame_in];
        end
        default: begin
          want.status = ST_INVALID;
        end
      endcase
      want.used_count = 9'(taken_count);
      expected_q.push_back(want);
    endfunction

    function void mismatch(string what, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_result(ffa_out_t got);
      ffa_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result without pending transfer, expected none actual %h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.frame_out !== want.frame_out) mismatch("frame_out", want.frame_out, got.frame_out);
      if (got.is_used !== want.is_used) mismatch("is_used", want.is_used, got.is_used);
      if (got.status !== want.status) mismatch("status", want.status, got.status);
      if (got.used_count !== want.used_count)
        mismatch("used_count", want.used_count, got.used_count);
    endfunction
  endclass

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  ffa_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  ffa_out_t out_item;

  alloc_scoreboard sb;
  int              burst_left = 0;
  int              idle_cycles = 0;

  first_fit_frame_allocator_unit #(
    .NUM_FRAMES     (NUM_FRAMES),
    .RESERVED_FRAMES(RESERVED_FRAMES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic ffa_in_t make_cmd(logic [1:0] op, logic [7:0] frame);
    ffa_in_t c;
    c.op       = op;
    c.frame_in = frame;
    return c;
  endfunction

  // alloc_pct steers the fill level of the map
  function automatic ffa_in_t pick_cmd(int alloc_pct);
    ffa_in_t c;
    int      r;
    int      k;
    r = $urandom_range(99);
    c.frame_in = 8'($urandom_range(255, 0));
    if (r < alloc_pct) begin
      c.op = OP_ALLOC;
    end else begin
      k = $urandom_range(9);
      if (k < 6) begin
        c.op = OP_FREE;
        if ($urandom_range(99) < 85)
          c.frame_in = 8'($urandom_range(NUM_FRAMES - 1, RESERVED_FRAMES));
        else
          c.frame_in = 8'($urandom_range(RESERVED_FRAMES - 1, 0));
      end else if (k < 9) begin
        c.op = OP_QUERY;
      end else begin
        c.op = OP_BAD;
      end
    end
    return c;
  endfunction

  task automatic send_cmd(ffa_in_t cmd);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (!(start && !busy));
    sb.note_cmd(in_item);
  endtask

  initial begin : stimulus
    int wait_cnt;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_cmd(make_cmd(OP_ALLOC, 8'd0));
    send_cmd(make_cmd(OP_ALLOC, 8'd255));
    send_cmd(make_cmd(OP_ALLOC, 8'd0));
    send_cmd(make_cmd(OP_QUERY, 8'd0));
    send_cmd(make_cmd(OP_QUERY, 8'd15));
    send_cmd(make_cmd(OP_QUERY, 8'd16));
    send_cmd(make_cmd(OP_QUERY, 8'd19));
    send_cmd(make_cmd(OP_QUERY, 8'd255));
    // kernel frames cannot be released
    send_cmd(make_cmd(OP_FREE, 8'd0));
    send_cmd(make_cmd(OP_FREE, 8'd15));
    // releasing free frame 255 leaves the map alone; frame 17 is in use and is released
    send_cmd(make_cmd(OP_FREE, 8'd255));
    send_cmd(make_cmd(OP_FREE, 8'd17));
    send_cmd(make_cmd(OP_QUERY, 8'd17));
    send_cmd(make_cmd(OP_ALLOC, 8'd170));
    send_cmd(make_cmd(OP_FREE, 8'd16));
    send_cmd(make_cmd(OP_FREE, 8'd16));
    send_cmd(make_cmd(OP_BAD, 8'd0));
    send_cmd(make_cmd(OP_BAD, 8'd255));
    send_cmd(make_cmd(OP_ALLOC, 8'd85));
    send_cmd(make_cmd(OP_QUERY, 8'd16));

    // fill until full, drain, then mixed traffic
    repeat (360) send_cmd(pick_cmd(90));
    repeat (300) send_cmd(pick_cmd(10));
    repeat (190) send_cmd(pick_cmd(50));
    start <= 1'b0;

    for (wait_cnt = 0; wait_cnt < DRAIN_LIMIT && sb.expected_q.size() != 0; wait_cnt++)
      @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (sb.errors == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
design/ffa_pkg.sv
design/ffa_cell.sv
design/first_fit_frame_allocator_unit.sv
tb/sv/tb_first_fit_frame_allocator_unit.sv
